// ===== src/sdta_pkg.sv =====
package sdta_pkg;

   localparam int TABLE_DEPTH_DEF = 1024;
   localparam int ID_BITS_DEF     = 16;

   localparam int VID_W  = 16;
   localparam int COMP_W = 32;
   localparam int NCOMP  = 6;
   localparam int CAP_W  = 11;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_APPLY  = 1'b1;

   localparam logic [COMP_W-1:0] COMP_MAX = 32'h7fff_ffff;
   localparam logic [COMP_W-1:0] COMP_MIN = 32'h8000_0000;

   typedef logic [NCOMP-1:0][COMP_W-1:0] comp_vec_type;

   typedef struct packed {
      logic               cmd;
      logic [VID_W-1:0]   vertex_id;
      comp_vec_type       comp;
   } item_type;

   // head of the queue between front and back
   typedef struct packed {
      logic     valid;
      item_type item;
   } qhead_type;

endpackage

// ===== src/sdta_if.sv =====
interface sdta_req_if;
   logic                  valid;
   logic                  ready;
   logic                  command;
   logic [15:0]           vertex_id;
   logic signed [31:0]    pos_x;
   logic signed [31:0]    pos_y;
   logic signed [31:0]    pos_z;
   logic signed [31:0]    norm_x;
   logic signed [31:0]    norm_y;
   logic signed [31:0]    norm_z;

   modport source (output valid, command, vertex_id, pos_x, pos_y, pos_z,
                   norm_x, norm_y, norm_z, input ready);
   modport sink   (input valid, command, vertex_id, pos_x, pos_y, pos_z,
                   norm_x, norm_y, norm_z, output ready);
endinterface

interface sdta_rsp_if;
   logic                  valid;
   logic                  ready;
   logic                  ok;
   logic signed [31:0]    out_pos_x;
   logic signed [31:0]    out_pos_y;
   logic signed [31:0]    out_pos_z;
   logic signed [31:0]    out_norm_x;
   logic signed [31:0]    out_norm_y;
   logic signed [31:0]    out_norm_z;

   modport source (output valid, ok, out_pos_x, out_pos_y, out_pos_z,
                   out_norm_x, out_norm_y, out_norm_z, input ready);
   modport sink   (input valid, ok, out_pos_x, out_pos_y, out_pos_z,
                   out_norm_x, out_norm_y, out_norm_z, output ready);
endinterface

interface sdta_csr_if;
   logic                  valid;
   logic                  ready;
   logic [10:0]           data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== src/sdta_front.sv =====
module sdta_front (
   input  logic                 clock,
   input  logic                 reset,
   sdta_req_if.sink             req,
   output sdta_pkg::qhead_type  q_head,
   input  logic                 q_pop
);

   sdta_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   sdta_pkg::item_type push_item;

   assign req.ready = (cnt_ff != 2'd2);
   assign push      = req.valid && req.ready;

   always_comb begin
      push_item.cmd       = req.command;
      push_item.vertex_id = req.vertex_id;
      push_item.comp[0]   = req.pos_x;
      push_item.comp[1]   = req.pos_y;
      push_item.comp[2]   = req.pos_z;
      push_item.comp[3]   = req.norm_x;
      push_item.comp[4]   = req.norm_y;
      push_item.comp[5]   = req.norm_z;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      case ({push, q_pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign q_head.valid = (cnt_ff != 2'd0);
   assign q_head.item  = entry_ff[rd_ptr_ff];

endmodule

// ===== src/sdta_back.sv =====
module sdta_back #(
   parameter int TABLE_DEPTH = sdta_pkg::TABLE_DEPTH_DEF,
   parameter int ID_BITS     = sdta_pkg::ID_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sdta_pkg::qhead_type  q_head,
   output logic                 q_pop,
   sdta_rsp_if.source           rsp,
   sdta_csr_if.sink             csr
);

   localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W  = (CNT_W > sdta_pkg::CAP_W) ? CNT_W : sdta_pkg::CAP_W;
   localparam int VEC_W  = sdta_pkg::NCOMP * sdta_pkg::COMP_W;
   localparam int WORD_W = ID_BITS + VEC_W;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FWD  = 2'd1;
   localparam logic [1:0] S_BWD  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   function automatic logic [sdta_pkg::COMP_W-1:0] sat_add(
      input logic [sdta_pkg::COMP_W-1:0] a,
      input logic [sdta_pkg::COMP_W-1:0] b
   );
      logic [sdta_pkg::COMP_W:0] s;
      s = {a[sdta_pkg::COMP_W-1], a} + {b[sdta_pkg::COMP_W-1], b};
      if (s[sdta_pkg::COMP_W] != s[sdta_pkg::COMP_W-1]) begin
         return s[sdta_pkg::COMP_W] ? sdta_pkg::COMP_MIN : sdta_pkg::COMP_MAX;
      end
      return s[sdta_pkg::COMP_W-1:0];
   endfunction

   // table memory: id in the top bits, six offsets below
   logic [WORD_W-1:0] mem [TABLE_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [WORD_W-1:0] wr_data;

   logic [1:0]                  state_ff, state_in;
   logic [CNT_W-1:0]            cur_ff, cur_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic [ID_BITS-1:0]          prev_id_ff, prev_id_in;
   logic [ID_BITS-1:0]          last_id_ff, last_id_in;
   logic [sdta_pkg::CAP_W-1:0]  cap_ff, cap_in;
   logic [ID_BITS-1:0]          id_ff, id_in;
   sdta_pkg::comp_vec_type      core_ff, core_in;
   logic                        hit_ff, hit_in;
   sdta_pkg::comp_vec_type      cand_ff, cand_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   sdta_pkg::comp_vec_type      rsp_comp_ff, rsp_comp_in;

   logic                        out_free;
   logic [ID_BITS+sdta_pkg::VID_W-1:0] vid_ext;
   logic [ID_BITS-1:0]          head_id;
   logic [ID_BITS-1:0]          rd_id;
   sdta_pkg::comp_vec_type      rd_comp;
   logic                        room;
   logic                        accept;
   logic [CNT_W-1:0]            cur_inc;
   logic [CNT_W-1:0]            cur_dec;
   logic [CNT_W-1:0]            cur_dec2;

   assign csr.ready = 1'b1;

   assign vid_ext  = (ID_BITS + sdta_pkg::VID_W)'(q_head.item.vertex_id);
   assign head_id  = vid_ext[ID_BITS-1:0];
   assign rd_id    = rd_data_ff[WORD_W-1:VEC_W];
   assign rd_comp  = rd_data_ff[VEC_W-1:0];
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign room     = (CMP_W'(count_ff) < CMP_W'(cap_ff))
                  && (count_ff < CNT_W'(TABLE_DEPTH));
   assign accept   = room && ((count_ff == '0) || (head_id > last_id_ff));
   assign cur_inc  = cur_ff + CNT_W'(1);
   assign cur_dec  = cur_ff - CNT_W'(1);
   assign cur_dec2 = cur_ff - CNT_W'(2);
   assign wr_data  = {head_id, q_head.item.comp};

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      prev_id_in   = prev_id_ff;
      last_id_in   = last_id_ff;
      cap_in       = cap_ff;
      id_in        = id_ff;
      core_in      = core_ff;
      hit_in       = hit_ff;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_comp_in  = rsp_comp_ff;
      q_pop        = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;

      if (csr.valid) begin
         cap_in = csr.data;
      end
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_head.valid) begin
               if (q_head.item.cmd == sdta_pkg::CMD_APPEND) begin
                  if (out_free) begin
                     q_pop        = 1'b1;
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = accept;
                     rsp_comp_in  = '0;
                     if (accept) begin
                        wr_en      = 1'b1;
                        count_in   = count_ff + CNT_W'(1);
                        last_id_in = head_id;
                     end
                  end
               end else begin
                  q_pop   = 1'b1;
                  id_in   = head_id;
                  core_in = q_head.item.comp;
                  hit_in  = 1'b0;
                  if (cur_ff < count_ff) begin
                     rd_en    = 1'b1;
                     rd_addr  = cur_ff[ADDR_W-1:0];
                     state_in = S_FWD;
                  end else if ((cur_ff != '0) && (head_id <= prev_id_ff)) begin
                     rd_en    = 1'b1;
                     rd_addr  = cur_dec[ADDR_W-1:0];
                     state_in = S_BWD;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_FWD: begin
            // rd_data holds the entry under the cursor
            if (id_ff > rd_id) begin
               cur_in     = cur_inc;
               prev_id_in = rd_id;
               if (cur_inc < count_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = cur_inc[ADDR_W-1:0];
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               hit_in  = (id_ff == rd_id);
               cand_in = rd_comp;
               if ((cur_ff != '0) && (id_ff <= prev_id_ff)) begin
                  rd_en    = 1'b1;
                  rd_addr  = cur_dec[ADDR_W-1:0];
                  state_in = S_BWD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_BWD: begin
            // rd_data holds the entry just below the cursor
            if (id_ff <= rd_id) begin
               cur_in  = cur_dec;
               hit_in  = (id_ff == rd_id);
               cand_in = rd_comp;
               if (cur_dec != '0) begin
                  rd_en   = 1'b1;
                  rd_addr = cur_dec2[ADDR_W-1:0];
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               prev_id_in = rd_id;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = hit_ff;
               for (int j = 0; j < sdta_pkg::NCOMP; j++) begin
                  rsp_comp_in[j] = hit_ff ? sat_add(core_ff[j], cand_ff[j]) : core_ff[j];
               end
               if (hit_ff) begin
                  cur_in     = cur_inc;
                  prev_id_in = id_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         count_ff     <= '0;
         cap_ff       <= sdta_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_id_ff  <= prev_id_in;
      last_id_ff  <= last_id_in;
      id_ff       <= id_in;
      core_ff     <= core_in;
      hit_ff      <= hit_in;
      cand_ff     <= cand_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_comp_ff <= rsp_comp_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.ok         = rsp_ok_ff;
   assign rsp.out_pos_x  = rsp_comp_ff[0];
   assign rsp.out_pos_y  = rsp_comp_ff[1];
   assign rsp.out_pos_z  = rsp_comp_ff[2];
   assign rsp.out_norm_x = rsp_comp_ff[3];
   assign rsp.out_norm_y = rsp_comp_ff[4];
   assign rsp.out_norm_z = rsp_comp_ff[5];

endmodule

// ===== src/sparse_delta_table_apply.sv =====
// append word: passes the queue entry register, then the result register; apply
// word: popped, then the table walked one entry per read, then the result registered
// throughput: append 1 word per cycle while no apply is running and rsp is taken;
// an apply ends before the next word is taken; single read port, registered data
// reset: synchronous, clears count, cursor and queue, capacity returns to 1024;
// table memory is not cleared, entries at or above the count are never read
module sparse_delta_table_apply #(
   parameter int TABLE_DEPTH = sdta_pkg::TABLE_DEPTH_DEF,
   parameter int ID_BITS     = sdta_pkg::ID_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sdta_req_if.sink    req,
   sdta_rsp_if.source  rsp,
   sdta_csr_if.sink    csr
);

   sdta_pkg::qhead_type q_head;
   logic                q_pop;

   sdta_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_head (q_head),
      .q_pop  (q_pop)
   );

   sdta_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .q_head (q_head),
      .q_pop  (q_pop),
      .rsp    (rsp),
      .csr    (csr)
   );

endmodule
